>>> sv/assert_macros.svh
// Assertion helpers used by the RTL of the polar converter.
// Both macros expect a signal named clk in the scope of use; C2P_ASSERT also expects arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define C2P_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define C2P_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/c2p_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_pkg
// Types, widths, constants and the arctangent table of the polar converter.
// ----------------------------------------------------------------------------
package c2p_pkg;

	// Coordinate and datapath widths.
	localparam int COORD_WIDTH       = 16;
	localparam int CORDIC_ITERATIONS = 16;
	localparam int GUARD_BITS        = 12;
	localparam int ABS_W             = COORD_WIDTH + 1;
	localparam int XY_W              = COORD_WIDTH + GUARD_BITS + 4;
	localparam int Z_W               = 25;
	localparam int A_W               = 14;
	localparam int ANG_W             = 16;
	localparam int MAG_W             = 16;
	localparam int GAIN_W            = 16;
	localparam int PROD_W            = XY_W + GAIN_W - 1;
	localparam int NUM_STAGES        = CORDIC_ITERATIONS + 3;

	// Gain compensation of about 0.6072647 in Q31, split in two halves.
	localparam logic [GAIN_W-1:0] GAIN_HI = 16'd19898;
	localparam logic [GAIN_W-1:0] GAIN_LO = 16'd55764;

	// Angles: the accumulator counts 2^-16 degree, the result is Q9.7.
	localparam logic signed [Z_W-1:0] DEG90_Z   = 25'sd5898240;
	localparam logic [ANG_W:0]        DEG0_Q7   = 17'd0;
	localparam logic [ANG_W:0]        DEG90_Q7  = 17'd11520;
	localparam logic [ANG_W:0]        DEG180_Q7 = 17'd23040;
	localparam logic [ANG_W:0]        DEG270_Q7 = 17'd34560;
	localparam logic [ANG_W:0]        DEG360_Q7 = 17'd46080;

	// How a point is handled at the end of the pipeline.
	typedef enum logic [1:0] {
		KIND_GENERAL,
		KIND_ORIGIN,
		KIND_X_AXIS,
		KIND_Y_AXIS
	} c2p_kind_t;

	// One point in flight through the CORDIC stages.
	typedef struct packed {
		logic signed [XY_W-1:0] cx;
		logic signed [XY_W-1:0] cy;
		logic signed [Z_W-1:0]  z;
		c2p_kind_t              kind;
		logic                   x_neg;
		logic                   y_neg;
		logic [ABS_W-1:0]       axis_mag;
	} c2p_item_t;

	// One point after the gain multiplications.
	typedef struct packed {
		logic [PROD_W-1:0] p_hi;
		logic [PROD_W-1:0] p_lo;
		logic [A_W-1:0]    a;
		c2p_kind_t         kind;
		logic              x_neg;
		logic              y_neg;
		logic [ABS_W-1:0]  axis_mag;
	} c2p_mult_t;

	// One finished result.
	typedef struct packed {
		logic [ANG_W-1:0] angle_deg;
		logic [MAG_W-1:0] magnitude;
		logic             at_origin;
	} c2p_res_t;

	// atan(2^-idx) in units of 2^-16 degree, rounded to nearest.
	function automatic logic signed [Z_W-1:0] atan_step(input int unsigned idx);
		logic signed [Z_W-1:0] v;
		case (idx)
			0:       v = 25'sd2949120;
			1:       v = 25'sd1740967;
			2:       v = 25'sd919879;
			3:       v = 25'sd466945;
			4:       v = 25'sd234379;
			5:       v = 25'sd117304;
			6:       v = 25'sd58666;
			7:       v = 25'sd29335;
			8:       v = 25'sd14668;
			9:       v = 25'sd7334;
			10:      v = 25'sd3667;
			11:      v = 25'sd1833;
			12:      v = 25'sd917;
			13:      v = 25'sd458;
			14:      v = 25'sd229;
			15:      v = 25'sd115;
			16:      v = 25'sd57;
			17:      v = 25'sd29;
			18:      v = 25'sd14;
			19:      v = 25'sd7;
			20:      v = 25'sd4;
			21:      v = 25'sd2;
			22:      v = 25'sd1;
			default: v = 25'sd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

>>> sv/c2p_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Polar converter channels
// Valid/ready channels for the input point and for the polar result.
// ----------------------------------------------------------------------------
interface c2p_point_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [c2p_pkg::COORD_WIDTH-1:0] x_coord;
	logic signed [c2p_pkg::COORD_WIDTH-1:0] y_coord;

	modport source (output valid, output x_coord, output y_coord, input ready);
	modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface c2p_polar_if;
	logic                            valid;
	logic                            ready;
	logic [c2p_pkg::ANG_W-1:0]       angle_deg;
	logic [c2p_pkg::MAG_W-1:0]       magnitude;
	logic                            at_origin;

	modport source (output valid, output angle_deg, output magnitude, output at_origin,
		input ready);
	modport sink   (input valid, input angle_deg, input magnitude, input at_origin,
		output ready);
endinterface
`default_nettype wire

>>> sv/cartesian_to_polar_degrees.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cartesian_to_polar_degrees
// Converts a Q8.8 point to its angle in degrees (Q9.7) and its magnitude (Q8.8).
// ----------------------------------------------------------------------------
// Usage:
// A point enters on the point channel as a beat of x_coord and y_coord. Each
// point gives exactly one beat on the polar channel: angle_deg in [0,360)
// degrees, magnitude, and at_origin, which is set (with angle and magnitude
// zero) when both coordinates are zero.
// The datapath is a pipeline of CORDIC_ITERATIONS + 3 registers: a folding
// stage, one stage per CORDIC iteration, a gain multiply stage and the output
// register. One point is accepted every cycle, except while the receiver
// stalls a shown result by holding ready low.
// When the receiver holds ready low while a result is shown, the whole
// pipeline holds its contents and point.ready drops in the same cycle; no
// beat is lost or repeated, and flow resumes the cycle ready returns.
// Reset clears every stage valid bit and holds point.ready low, so the block
// comes up empty and ready once reset is released.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cartesian_to_polar_degrees (
	input  wire logic         clk,
	input  wire logic         arst_n,
	c2p_point_if.sink         point,
	c2p_polar_if.source       polar
);
	import c2p_pkg::*;

	logic                  adv;
	logic [NUM_STAGES-1:0] vld_s;
	c2p_item_t             fold_d;
	c2p_item_t             fold_s1;
	c2p_item_t             cordic_s [CORDIC_ITERATIONS];
	c2p_mult_t             mult_d;
	c2p_mult_t             mult_s;
	c2p_res_t              res_d;
	c2p_res_t              out_s;

	// The pipeline moves whenever the output register is free or drained.
	// No point is taken while reset is asserted.
	assign adv         = !vld_s[NUM_STAGES-1] || polar.ready;
	assign point.ready = adv && arst_n;

	// Stage valid bits shift along with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NUM_STAGES-2:0], point.valid};
		end
	end

	// Fold the point into the first quadrant and classify it.
	always_comb begin
		logic signed [ABS_W-1:0] xe;
		logic signed [ABS_W-1:0] ye;
		logic [ABS_W-1:0]        ax;
		logic [ABS_W-1:0]        ay;
		xe = {point.x_coord[COORD_WIDTH-1], point.x_coord};
		ye = {point.y_coord[COORD_WIDTH-1], point.y_coord};
		ax = xe[ABS_W-1] ? ABS_W'(-xe) : ABS_W'(xe);
		ay = ye[ABS_W-1] ? ABS_W'(-ye) : ABS_W'(ye);
		fold_d.cx       = XY_W'({ax, {GUARD_BITS{1'b0}}});
		fold_d.cy       = XY_W'({ay, {GUARD_BITS{1'b0}}});
		fold_d.z        = '0;
		fold_d.x_neg    = point.x_coord[COORD_WIDTH-1];
		fold_d.y_neg    = point.y_coord[COORD_WIDTH-1];
		fold_d.axis_mag = ax;
		if (ax == '0 && ay == '0) begin
			fold_d.kind = KIND_ORIGIN;
		end else if (ax == '0) begin
			fold_d.kind     = KIND_Y_AXIS;
			fold_d.axis_mag = ay;
		end else if (ay == '0) begin
			fold_d.kind = KIND_X_AXIS;
		end else begin
			fold_d.kind = KIND_GENERAL;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fold_s1 <= fold_d;
		end
	end

	// One vectoring iteration per stage, driving y toward zero.
	for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_iter
		c2p_item_t prev;
		c2p_item_t next;

		if (i == 0) begin : g_first
			assign prev = fold_s1;
		end else begin : g_rest
			assign prev = cordic_s[i-1];
		end

		always_comb begin
			logic signed [XY_W-1:0] dx;
			logic signed [XY_W-1:0] dy;
			dx   = prev.cy >>> i;
			dy   = prev.cx >>> i;
			next = prev;
			if (!prev.cy[XY_W-1]) begin
				next.cx = prev.cx + dx;
				next.cy = prev.cy - dy;
				next.z  = prev.z + atan_step(i);
			end else begin
				next.cx = prev.cx - dx;
				next.cy = prev.cy + dy;
				next.z  = prev.z - atan_step(i);
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				cordic_s[i] <= next;
			end
		end
	end

	// Clamp and round the angle, start the gain compensation products.
	always_comb begin
		c2p_item_t               last;
		logic [XY_W-2:0]         ux;
		logic signed [Z_W-1:0]   zc;
		logic [Z_W-1:0]          zr;
		last = cordic_s[CORDIC_ITERATIONS-1];
		ux   = last.cx[XY_W-1] ? '0 : last.cx[XY_W-2:0];
		if (last.z[Z_W-1]) begin
			zc = '0;
		end else if (last.z > DEG90_Z) begin
			zc = DEG90_Z;
		end else begin
			zc = last.z;
		end
		zr              = Z_W'(zc) + Z_W'(256);
		mult_d.a        = zr[A_W+8:9];
		mult_d.p_hi     = PROD_W'(ux) * PROD_W'(GAIN_HI);
		mult_d.p_lo     = PROD_W'(ux) * PROD_W'(GAIN_LO);
		mult_d.kind     = last.kind;
		mult_d.x_neg    = last.x_neg;
		mult_d.y_neg    = last.y_neg;
		mult_d.axis_mag = last.axis_mag;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mult_s <= mult_d;
		end
	end

	// Finish the magnitude and map the angle back to its quadrant.
	always_comb begin
		logic [PROD_W:0]      prod;
		logic [PROD_W:0]      rnd;
		logic [PROD_W-27:0]   mag_w;
		logic [ANG_W:0]       ang;
		logic [ANG_W:0]       a_ext;
		prod  = {1'b0, mult_s.p_hi} + (PROD_W + 1)'(mult_s.p_lo >> 16);
		rnd   = prod + ((PROD_W + 1)'(1) << 26);
		mag_w = rnd[PROD_W:27];
		a_ext = (ANG_W + 1)'(mult_s.a);
		if (!mult_s.x_neg) begin
			ang = mult_s.y_neg ? DEG360_Q7 - a_ext : a_ext;
		end else begin
			ang = mult_s.y_neg ? DEG180_Q7 + a_ext : DEG180_Q7 - a_ext;
		end
		if (ang >= DEG360_Q7) begin
			ang = ang - DEG360_Q7;
		end
		res_d.at_origin = 1'b0;
		case (mult_s.kind)
			KIND_ORIGIN: begin
				res_d.angle_deg = '0;
				res_d.magnitude = '0;
				res_d.at_origin = 1'b1;
			end
			KIND_X_AXIS: begin
				res_d.angle_deg = ANG_W'(mult_s.x_neg ? DEG180_Q7 : DEG0_Q7);
				res_d.magnitude = (mult_s.axis_mag > ABS_W'({MAG_W{1'b1}})) ?
					{MAG_W{1'b1}} : mult_s.axis_mag[MAG_W-1:0];
			end
			KIND_Y_AXIS: begin
				res_d.angle_deg = ANG_W'(mult_s.y_neg ? DEG270_Q7 : DEG90_Q7);
				res_d.magnitude = (mult_s.axis_mag > ABS_W'({MAG_W{1'b1}})) ?
					{MAG_W{1'b1}} : mult_s.axis_mag[MAG_W-1:0];
			end
			default: begin
				res_d.angle_deg = ang[ANG_W-1:0];
				res_d.magnitude = (mag_w > (PROD_W - 26)'({MAG_W{1'b1}})) ?
					{MAG_W{1'b1}} : mag_w[MAG_W-1:0];
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (adv) begin
			out_s <= res_d;
		end
	end

	assign polar.valid     = vld_s[NUM_STAGES-1];
	assign polar.angle_deg = out_s.angle_deg;
	assign polar.magnitude = out_s.magnitude;
	assign polar.at_origin = out_s.at_origin;

	// Checks on the pipeline control and the result encoding.
	`C2P_ASSERT(a_accept_enters, point.valid && point.ready |=> vld_s[0], "accepted beat did not enter stage one")
	`C2P_ASSERT(a_hold_on_stall, !adv |=> $stable(vld_s), "pipeline moved while stalled")
	`C2P_ASSERT(a_angle_range, polar.valid |-> polar.angle_deg < ANG_W'(DEG360_Q7), "angle not below 360 degrees")
	`C2P_ASSERT(a_origin_zero, polar.valid && polar.at_origin |-> polar.angle_deg == '0 && polar.magnitude == '0, "origin result not zero")
	`C2P_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !polar.valid, "result shown during reset")

endmodule
`default_nettype wire

>>> tb/c2p_polar_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_polar_checker
// Watches both channels of the polar converter, predicts each result from the
// accepted point and compares every polar beat field by field with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module c2p_polar_checker
	import c2p_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	c2p_point_if        point,
	c2p_polar_if        polar,
	output int          fail_count,
	output int          pending,
	output int          n_checked,
	output int          n_origin,
	output int          n_axis
);

	// atan(2^-i) in units of 2^-16 degree.
	localparam int ATAN_LEN = 24;
	localparam longint ATAN_Q16 [ATAN_LEN] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	// A predicted result together with the point it came from.
	typedef struct {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		c2p_res_t                      res;
	} polar_expect_t;

	polar_expect_t polar_due_q [$];
	int            mism;
	int            checked;
	int            origins;
	int            axes;

	// Clamp a magnitude to the 16-bit output range.
	function automatic longint clip16(input longint v);
		return (v > 65535) ? 65535 : v;
	endfunction

	// Angle in Q9.7 degrees and magnitude in Q8.8 of one point.
	function automatic c2p_res_t polar_of(input logic signed [COORD_WIDTH-1:0] x_in,
			input logic signed [COORD_WIDTH-1:0] y_in);
		longint   x, y, ax, ay, cx, cy, z, dx, dy, ux, prod, a, ang;
		c2p_res_t r;
		x = longint'(x_in);
		y = longint'(y_in);
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		r.at_origin = 1'b0;
		if (x == 0 && y == 0) begin
			r.angle_deg = '0;
			r.magnitude = '0;
			r.at_origin = 1'b1;
		end else if (x == 0) begin
			r.angle_deg = (y > 0) ? DEG90_Q7[ANG_W-1:0] : DEG270_Q7[ANG_W-1:0];
			r.magnitude = MAG_W'(clip16(ay));
		end else if (y == 0) begin
			r.angle_deg = (x > 0) ? DEG0_Q7[ANG_W-1:0] : DEG180_Q7[ANG_W-1:0];
			r.magnitude = MAG_W'(clip16(ax));
		end else begin
			// Vectoring rotations on the first-quadrant fold of the point.
			cx = ax << GUARD_BITS;
			cy = ay << GUARD_BITS;
			z = 0;
			for (int i = 0; i < CORDIC_ITERATIONS && i < ATAN_LEN; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (cy >= 0) begin
					cx = cx + dx;
					cy = cy - dy;
					z = z + ATAN_Q16[i];
				end else begin
					cx = cx - dx;
					cy = cy + dy;
					z = z - ATAN_Q16[i];
				end
			end
			if (z < 0)
				z = 0;
			if (z > longint'(DEG90_Z))
				z = longint'(DEG90_Z);
			a = (z + 256) >>> 9;

			// Map the folded angle back to the quadrant of the point.
			if (x > 0)
				ang = (y > 0) ? a : longint'(DEG360_Q7) - a;
			else
				ang = (y > 0) ? longint'(DEG180_Q7) - a : longint'(DEG180_Q7) + a;
			if (ang >= longint'(DEG360_Q7))
				ang = ang - longint'(DEG360_Q7);
			r.angle_deg = ang[ANG_W-1:0];

			// Gain compensation with the split Q31 constant.
			ux = (cx < 0) ? 0 : cx;
			prod = ux * longint'(GAIN_HI) + ((ux * longint'(GAIN_LO)) >>> 16);
			r.magnitude = MAG_W'(clip16((prod + (longint'(1) << 26)) >>> 27));
		end
		return r;
	endfunction

	// Result beats are matched first, then the new point beat is predicted.
	always @(posedge clk) begin
		polar_expect_t e;
		if (arst_n) begin
			if (polar.valid && polar.ready) begin
				if (polar_due_q.size() == 0) begin
					$error("polar beat with nothing predicted: angle_deg %0d magnitude %0d",
						polar.angle_deg, polar.magnitude);
					mism++;
				end else begin
					e = polar_due_q.pop_front();
					checked++;
					if (e.res.at_origin)
						origins++;
					else if (e.x == 0 || e.y == 0)
						axes++;
					if (polar.angle_deg !== e.res.angle_deg) begin
						$error("angle_deg for (%0d,%0d): expected %0d, actual %0d",
							e.x, e.y, e.res.angle_deg, polar.angle_deg);
						mism++;
					end
					if (polar.magnitude !== e.res.magnitude) begin
						$error("magnitude for (%0d,%0d): expected %0d, actual %0d",
							e.x, e.y, e.res.magnitude, polar.magnitude);
						mism++;
					end
					if (polar.at_origin !== e.res.at_origin) begin
						$error("at_origin for (%0d,%0d): expected %0d, actual %0d",
							e.x, e.y, e.res.at_origin, polar.at_origin);
						mism++;
					end
				end
			end
			if (point.valid && point.ready) begin
				e.x = point.x_coord;
				e.y = point.y_coord;
				e.res = polar_of(point.x_coord, point.y_coord);
				polar_due_q.push_back(e);
			end
			pending <= polar_due_q.size();
			fail_count <= mism;
			n_checked <= checked;
			n_origin <= origins;
			n_axis <= axes;
		end
	end

endmodule

>>> tb/tb_cartesian_to_polar_degrees.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cartesian_to_polar_degrees
// Drives points into the polar converter, first a directed set of axes,
// extremes and wrap cases, then random phases with varied idling on both
// channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_cartesian_to_polar_degrees;
	import c2p_pkg::*;

	localparam int LIMIT_CYCLES  = 200000;
	localparam int TAIL_CYCLES   = 40;
	localparam int NUM_PHASES    = 5;
	localparam int PHASE_POINTS  = 160;

	logic clk;
	logic arst_n;
	int   cycles;
	int   snd_max;
	int   rcv_max;
	int   points_sent;
	int   fail_count;
	int   pending;
	int   n_checked;
	int   n_origin;
	int   n_axis;

	c2p_point_if point_ch ();
	c2p_polar_if polar_ch ();

	cartesian_to_polar_degrees dut (
		.clk    (clk),
		.arst_n (arst_n),
		.point  (point_ch),
		.polar  (polar_ch)
	);

	c2p_polar_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.point      (point_ch),
		.polar      (polar_ch),
		.fail_count (fail_count),
		.pending    (pending),
		.n_checked  (n_checked),
		.n_origin   (n_origin),
		.n_axis     (n_axis)
	);

	// Clock.
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Run limit.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Offer one point beat after a random gap and hold it until accepted.
	task automatic send_point(input logic signed [COORD_WIDTH-1:0] x,
			input logic signed [COORD_WIDTH-1:0] y);
		int gap;
		gap = (snd_max == 0) ? 0 : $urandom_range(snd_max, 0);
		if (gap > 0) begin
			point_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point_ch.valid <= 1'b1;
		point_ch.x_coord <= x;
		point_ch.y_coord <= y;
		@(posedge clk);
		while (!point_ch.ready)
			@(posedge clk);
		points_sent++;
	endtask

	// Lower valid and wait until every predicted result has been seen.
	task automatic drain_results();
		point_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Result side: a random stall before each beat, then ready until one lands.
	initial begin
		polar_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			int stall;
			stall = (rcv_max == 0) ? 0 : $urandom_range(rcv_max, 0);
			if (stall > 0) begin
				polar_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			polar_ch.ready <= 1'b1;
			@(posedge clk);
			while (!polar_ch.valid)
				@(posedge clk);
		end
	end

	// Stimulus and verdict.
	initial begin
		logic signed [COORD_WIDTH-1:0] rx;
		logic signed [COORD_WIDTH-1:0] ry;
		int                            kind;
		int                            smax [NUM_PHASES];
		int                            rmax [NUM_PHASES];
		smax = '{0, 15, 0, 15, 4};
		rmax = '{0, 15, 15, 0, 2};
		points_sent = 0;
		snd_max = 3;
		rcv_max = 3;
		arst_n <= 1'b0;
		point_ch.valid <= 1'b0;
		point_ch.x_coord <= '0;
		point_ch.y_coord <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Origin and the four half axes, with the extreme coordinates.
		send_point(16'sd0, 16'sd0);
		send_point(16'sd0, 16'sd256);
		send_point(16'sd0, 16'sd32767);
		send_point(16'sd0, 16'sh8000);
		send_point(16'sd1, 16'sd0);
		send_point(16'sd32767, 16'sd0);
		send_point(16'sh8000, 16'sd0);
		send_point(-16'sd1, 16'sd0);
		// Corners of the coordinate range, the largest magnitudes.
		send_point(16'sd32767, 16'sd32767);
		send_point(16'sh8000, 16'sh8000);
		send_point(16'sh8000, 16'sd32767);
		send_point(16'sd32767, 16'sh8000);
		// Smallest diagonal points in each quadrant.
		send_point(16'sd1, 16'sd1);
		send_point(-16'sd1, 16'sd1);
		send_point(-16'sd1, -16'sd1);
		send_point(16'sd1, -16'sd1);
		// Just below the positive x axis, where the angle rounds up to 360.
		send_point(16'sd32767, -16'sd1);
		send_point(16'sd32767, -16'sd2);
		// Near the y axis, where the folded angle clamps at 90 degrees, and one point near the negative x axis.
		send_point(16'sd1, 16'sd32767);
		send_point(-16'sd1, 16'sh8000);
		send_point(16'sd1, -16'sd32767);
		send_point(-16'sd32767, 16'sd1);
		// Mixed bit patterns.
		send_point(16'sh5555, -16'sh2AAB);
		send_point(-16'sh5556, 16'sh2AAA);
		drain_results();

		// Random phases, each with its own idling on both sides.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			snd_max = smax[ph];
			rcv_max = rmax[ph];
			for (int n = 0; n < PHASE_POINTS; n++) begin
				kind = $urandom_range(99, 0);
				rx = COORD_WIDTH'($urandom());
				ry = COORD_WIDTH'($urandom());
				if (kind < 5) begin
					rx = '0;
					ry = '0;
				end else if (kind < 15) begin
					if ($urandom_range(1, 0))
						rx = '0;
					else
						ry = '0;
				end else if (kind < 30) begin
					rx = COORD_WIDTH'($urandom_range(8, 0) - 4);
					ry = COORD_WIDTH'($urandom_range(8, 0) - 4);
				end else if (kind < 40) begin
					case ($urandom_range(3, 0))
						0: rx = 16'sh8000;
						1: rx = 16'sd32767;
						2: rx = -16'sd1;
						default: rx = 16'sd1;
					endcase
				end else if (kind < 50) begin
					case ($urandom_range(3, 0))
						0: ry = 16'sh8000;
						1: ry = 16'sd32767;
						2: ry = -16'sd1;
						default: ry = 16'sd1;
					endcase
				end
				send_point(rx, ry);
			end
			// Hold off the sender until the pipeline is empty.
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d points, checked %0d polar beats: %0d at the origin, %0d on an axis.",
			points_sent, n_checked, n_origin, n_axis);
		$display("Idling covered no gaps, sender gaps, result stalls and both at once.");
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
